// ===== hw/rtl/bounded_integer_set_assert.svh =====
// Assertion macros used by the checker file.
`ifndef BOUNDED_INTEGER_SET_ASSERT_SVH
`define BOUNDED_INTEGER_SET_ASSERT_SVH

// Same-cycle implication, dropped while reset is high.
`define BIS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bounded_integer_set: same-cycle check failed");

// Next-cycle implication, dropped while reset is high.
`define BIS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bounded_integer_set: next-cycle check failed");

// Next-cycle implication that also holds through reset.
`define BIS_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("bounded_integer_set: reset check failed");

`endif

// ===== hw/rtl/bis_pkg.sv =====
`timescale 1ns / 1ps
package bis_pkg;

   localparam int VALUE_W = 32;
   localparam int CMD_W   = 2;
   localparam int COUNT_W = 5;

   typedef enum logic [CMD_W-1:0] {
      CMD_ADD    = 2'd0,
      CMD_REMOVE = 2'd1,
      CMD_QUERY  = 2'd2
   } cmd_type;

   // Broadcast from the top level to every cell.
   typedef struct packed {
      logic                       add_en;
      logic                       remove_en;
      logic signed [VALUE_W-1:0]  value;
   } cell_ctl_type;

endpackage

// ===== hw/rtl/bis_if.sv =====
`timescale 1ns / 1ps
interface bis_req_if;
   import bis_pkg::*;

   logic                       valid;
   logic                       ready;
   logic [CMD_W-1:0]           command;
   logic signed [VALUE_W-1:0]  value;

   modport source  (output valid, output command, output value, input ready);
   modport sink    (input valid, input command, input value, output ready);
   modport monitor (input valid, input command, input value, input ready);
endinterface

interface bis_rsp_if;
   import bis_pkg::*;

   logic                valid;
   logic                ready;
   logic                was_present;
   logic [COUNT_W-1:0]  member_count;
   logic                is_empty;
   logic                add_rejected;

   modport source  (output valid, output was_present, output member_count,
                    output is_empty, output add_rejected, input ready);
   modport sink    (input valid, input was_present, input member_count,
                    input is_empty, input add_rejected, output ready);
   modport monitor (input valid, input was_present, input member_count,
                    input is_empty, input add_rejected, input ready);
endinterface

// ===== hw/rtl/bis_cell.sv =====
`timescale 1ns / 1ps
module bis_cell (
   input  logic                               clock,
   input  bis_pkg::cell_ctl_type              ctl,
   input  logic                               occupied,
   input  logic                               at_tail,
   input  logic                               shift_in,
   input  logic signed [bis_pkg::VALUE_W-1:0] next_value,
   output logic signed [bis_pkg::VALUE_W-1:0] value_out,
   output logic                               shift_out
);
   import bis_pkg::*;

   logic signed [VALUE_W-1:0] value_ff;
   logic signed [VALUE_W-1:0] value_in;
   logic                      hit;

   assign hit       = occupied && (value_ff == ctl.value);
   // Set at the matching cell and at every cell after it.
   assign shift_out = shift_in || hit;
   assign value_out = value_ff;

   always_comb begin
      value_in = value_ff;
      if (ctl.remove_en && shift_out) begin
         value_in = next_value;   // pull the neighbor down over the hole
      end else if (ctl.add_en && at_tail) begin
         value_in = ctl.value;    // append at the first free slot
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

// ===== hw/rtl/bounded_integer_set.sv =====
`timescale 1ns / 1ps
// Set of distinct 32-bit signed integers with room for CAPACITY values. Each
// request word carries a command (add, remove, query; code 3 acts as a query)
// and a value, and yields exactly one response word: whether the value was
// present before, the member count after, an empty flag, and a rejection flag
// for an add of a new value into a full set. Values sit in a row of cells in
// insertion order; a remove pulls every later cell down one place. One word
// is accepted per clock cycle and its response appears in the output register
// on the next cycle; a request is still accepted while the response waits, as
// long as the response is taken in the same cycle. All cells compare and
// update in the accepting cycle, and the match flag ripples from cell to cell,
// so the logic depth of that cycle grows with CAPACITY. No clearing pass is
// needed after reset; the request side stays not ready while reset is high.
// member_count carries the low 5 bits of the count.
module bounded_integer_set #(
   parameter int CAPACITY = 16
) (
   input  logic         clock,
   input  logic         reset,
   bis_req_if.sink      req_port,
   bis_rsp_if.source    rsp_port
);
   import bis_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);

   logic [CNT_W-1:0]           count_ff;
   logic [CNT_W-1:0]           count_in;
   logic                       rsp_valid_ff;
   logic                       rsp_valid_in;
   logic                       was_present_ff;
   logic [COUNT_W-1:0]         member_count_ff;
   logic                       is_empty_ff;
   logic                       add_rejected_ff;
   logic [CNT_W+COUNT_W-1:0]   count_wide;

   logic                       accept;
   logic                       is_add;
   logic                       is_remove;
   logic                       present;
   logic                       full;
   logic                       rejected;
   cell_ctl_type               ctl;

   logic signed [VALUE_W-1:0]  cell_value [CAPACITY];
   logic                       shift_chain [CAPACITY+1];

   // Take a new word whenever the response register is free or being drained.
   assign req_port.ready = !reset && (!rsp_valid_ff || rsp_port.ready);
   assign accept         = req_port.valid && req_port.ready;

   always_comb begin
      is_add    = 1'b0;
      is_remove = 1'b0;
      case (req_port.command)
         CMD_ADD:    is_add    = 1'b1;
         CMD_REMOVE: is_remove = 1'b1;
         CMD_QUERY:  ;
         default:    ;   // unused code: look only
      endcase
   end

   assign full     = (count_ff == CNT_W'(CAPACITY));
   assign present  = shift_chain[CAPACITY];
   assign rejected = is_add && !present && full;

   assign ctl.add_en    = accept && is_add && !present && !full;
   assign ctl.remove_en = accept && is_remove && present;
   assign ctl.value     = req_port.value;

   // Row of cells: the match flag runs from cell 0 toward the last cell.
   assign shift_chain[0] = 1'b0;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [VALUE_W-1:0] next_value;

      if (i == CAPACITY - 1) begin : g_last
         assign next_value = cell_value[i];   // leaves the valid range anyway
      end else begin : g_mid
         assign next_value = cell_value[i+1];
      end

      bis_cell u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .occupied   (CNT_W'(i) < count_ff),
         .at_tail    (CNT_W'(i) == count_ff),
         .shift_in   (shift_chain[i]),
         .next_value (next_value),
         .value_out  (cell_value[i]),
         .shift_out  (shift_chain[i+1])
      );
   end

   always_comb begin
      count_in = count_ff;
      if (ctl.add_en) begin
         count_in = count_ff + CNT_W'(1);
      end else if (ctl.remove_en) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   // Load on accept, drop once taken, hold while stalled.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_port.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign count_wide = {{COUNT_W{1'b0}}, count_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         was_present_ff  <= present;
         member_count_ff <= count_wide[COUNT_W-1:0];
         is_empty_ff     <= (count_in == '0);
         add_rejected_ff <= rejected;
      end
   end

   assign rsp_port.valid        = rsp_valid_ff;
   assign rsp_port.was_present  = was_present_ff;
   assign rsp_port.member_count = member_count_ff;
   assign rsp_port.is_empty     = is_empty_ff;
   assign rsp_port.add_rejected = add_rejected_ff;

endmodule

// ===== hw/rtl/bis_checker.sv =====
`timescale 1ns / 1ps
`include "bounded_integer_set_assert.svh"
module bis_checker #(
   parameter int CAPACITY = 16
) (
   input logic        clock,
   input logic        reset,
   bis_req_if.sink    req_port,
   bis_rsp_if.source  rsp_port
);
   import bis_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);

   logic [CNT_W+COUNT_W-1:0] cap_wide;
   logic [COUNT_W-1:0]       cap_low;
   logic                     rsp_stall;
   logic [COUNT_W+2:0]       rsp_word;
   logic                     empty_ok;
   logic                     reject_ok;

   assign cap_wide  = {{COUNT_W{1'b0}}, CNT_W'(CAPACITY)};
   assign cap_low   = cap_wide[COUNT_W-1:0];
   assign rsp_stall = rsp_port.valid && !rsp_port.ready;
   assign rsp_word  = {rsp_port.was_present, rsp_port.member_count,
                       rsp_port.is_empty, rsp_port.add_rejected};
   assign empty_ok  = rsp_port.is_empty == (rsp_port.member_count == '0);
   assign reject_ok = !rsp_port.was_present && (rsp_port.member_count == cap_low);

   `BIS_ASSERT_NEXT_ALWAYS(a_reset_clears_rsp, clock, reset, !rsp_port.valid)
   `BIS_ASSERT_NEXT(a_rsp_held, clock, reset, rsp_stall, rsp_port.valid && $stable(rsp_word))
   `BIS_ASSERT_IMPLY(a_empty_flag, clock, reset, rsp_port.valid, empty_ok)
   `BIS_ASSERT_IMPLY(a_reject_full, clock, reset, rsp_port.valid && rsp_port.add_rejected, reject_ok)
   `BIS_ASSERT_NEXT(a_no_accept_stalled, clock, reset, rsp_stall && !req_port.ready, rsp_port.valid)

endmodule

bind bounded_integer_set bis_checker #(.CAPACITY(CAPACITY)) u_bis_checker (
   .clock    (clock),
   .reset    (reset),
   .req_port (req_port),
   .rsp_port (rsp_port)
);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
   import bis_pkg::*;

   localparam int CAPACITY    = 16;
   localparam int RANDOM_WORDS = 500;
   localparam int POOL_SIZE    = 24;
   localparam int HOLD_CYCLES  = 200;   // long receiver hold-off
   localparam int HOLD_AFTER   = 150;   // responses taken before the hold-off
   localparam int DRAIN_CYCLES = 4;     // quiet time after the last response
   localparam int CYCLE_LIMIT  = 60000;
   localparam int REPORT_LIMIT = 10;

   // Code 3 is unused by the block and behaves as a query.
   localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

   typedef logic signed [VALUE_W-1:0] value_type;

   typedef struct packed {
      logic               was_present;
      logic [COUNT_W-1:0] member_count;
      logic               is_empty;
      logic               add_rejected;
   } answer_type;

   // Shadow copy of the set: predicts the answer of every accepted request
   // word and compares the response words against those predictions in order.
   class set_shadow;
      value_type  entries[CAPACITY];
      int         stored;
      answer_type pending_answers[$];
      int         failures;

      function new();
         stored   = 0;
         failures = 0;
      endfunction

      function int outstanding();
         return pending_answers.size();
      endfunction

      // Apply one accepted request to the shadow set and queue its answer.
      function void apply_request(logic [CMD_W-1:0] cmd, value_type val);
         int         pos;
         answer_type ans;
         pos = -1;
         for (int i = 0; i < stored; i++) begin
            if (pos < 0 && entries[i] == val) begin
               pos = i;
            end
         end
         ans.was_present  = (pos >= 0);
         ans.add_rejected = 1'b0;
         case (cmd)
            CMD_ADD: begin
               if (pos < 0) begin
                  if (stored >= CAPACITY) begin
                     ans.add_rejected = 1'b1;
                  end else begin
                     entries[stored] = val;
                     stored++;
                  end
               end
            end
            CMD_REMOVE: begin
               if (pos >= 0) begin
                  // close the gap: every later entry moves down one slot
                  for (int i = pos; i + 1 < stored; i++) begin
                     entries[i] = entries[i + 1];
                  end
                  stored--;
               end
            end
            default: begin
            end
         endcase
         ans.member_count = stored[COUNT_W-1:0];
         ans.is_empty     = (stored == 0);
         pending_answers.push_back(ans);
      endfunction

      // Check one accepted response against the oldest queued answer.
      function void compare_response(answer_type got);
         answer_type want;
         if (pending_answers.size() == 0) begin
            failures++;
            if (failures <= REPORT_LIMIT) begin
               $display("%0t: response with nothing outstanding: %0b %0d %0b %0b",
                        $realtime, got.was_present, got.member_count, got.is_empty,
                        got.add_rejected);
            end
            return;
         end
         want = pending_answers.pop_front();
         if (got.was_present !== want.was_present || got.member_count !== want.member_count ||
             got.is_empty !== want.is_empty || got.add_rejected !== want.add_rejected) begin
            failures++;
            if (failures <= REPORT_LIMIT) begin
               $display("%0t: mismatch present %0b/%0b count %0d/%0d empty %0b/%0b rej %0b/%0b",
                        $realtime, want.was_present, got.was_present,
                        want.member_count, got.member_count,
                        want.is_empty, got.is_empty, want.add_rejected, got.add_rejected);
            end
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   int   cycle_count = 0;

   bis_req_if req_bus ();
   bis_rsp_if rsp_bus ();

   set_shadow shadow;
   value_type pool[POOL_SIZE];

   bounded_integer_set #(
      .CAPACITY(CAPACITY)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_port(req_bus),
      .rsp_port(rsp_bus)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog: stop a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("bounded_integer_set regression: fail");
         $finish;
      end
   end

   // Offer one request word after a gap of idle cycles, then hold it until
   // the block takes it. Drive on the falling edge, sample on the rising edge.
   task automatic send_word(logic [CMD_W-1:0] cmd, value_type val, int gap);
      @(negedge clock);
      if (gap > 0) begin
         req_bus.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid   = 1'b1;
      req_bus.command = cmd;
      req_bus.value   = val;
      do @(posedge clock); while (!(req_bus.valid && req_bus.ready));
      shadow.apply_request(cmd, val);
   endtask

   // Weighted command choice: fill phases favor adds, drain phases removes,
   // so the set swings between empty and full.
   function automatic logic [CMD_W-1:0] pick_command(bit filling);
      int r;
      r = $urandom_range(0, 99);
      if (r < (filling ? 60 : 20)) return CMD_ADD;
      if (r < (filling ? 75 : 70)) return CMD_REMOVE;
      if (r < 95) return CMD_QUERY;
      return CMD_SPARE;
   endfunction

   // Most values come from a small pool so that hits are common; a few are
   // fresh random words.
   function automatic value_type pick_value();
      if ($urandom_range(0, 9) == 0) return value_type'($urandom);
      return pool[$urandom_range(0, POOL_SIZE - 1)];
   endfunction

   // Receiver: stall for a random time before each response word, with
   // stretches of no stall, and one long hold-off to back the block up.
   initial begin : receiver
      int         taken;
      int         stall;
      answer_type got;
      taken = 0;
      rsp_bus.ready = 1'b0;
      @(negedge reset);
      forever begin
         @(negedge clock);
         stall = ((taken % 50) < 12) ? 0 : $urandom_range(0, 3);
         if (taken == HOLD_AFTER) begin
            stall = HOLD_CYCLES;
         end
         if (stall > 0) begin
            rsp_bus.ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_bus.ready = 1'b1;
         do @(posedge clock); while (!(rsp_bus.valid && rsp_bus.ready));
         got.was_present  = rsp_bus.was_present;
         got.member_count = rsp_bus.member_count;
         got.is_empty     = rsp_bus.is_empty;
         got.add_rejected = rsp_bus.add_rejected;
         shadow.compare_response(got);
         taken++;
      end
   end

   initial begin : sender
      value_type last_fill;
      shadow          = new();
      reset           = 1'b1;
      req_bus.valid   = 1'b0;
      req_bus.command = CMD_QUERY;
      req_bus.value   = '0;
      pool[0] = value_type'(32'h8000_0000);
      pool[1] = value_type'(32'h7FFF_FFFF);
      pool[2] = '0;
      pool[3] = '1;
      for (int i = 4; i < POOL_SIZE; i++) begin
         pool[i] = value_type'($urandom);
      end
      repeat (12) @(negedge clock);
      reset = 1'b0;

      // Directed: extreme values, duplicates, absent lookups and removes,
      // the spare code, removal from the middle and the head, then fill to
      // capacity and try a new add and a duplicate add while full.
      send_word(CMD_ADD, value_type'(32'h8000_0000), 0);
      send_word(CMD_ADD, value_type'(32'h7FFF_FFFF), 0);
      send_word(CMD_ADD, '0, 1);
      send_word(CMD_ADD, '1, 0);
      send_word(CMD_ADD, '0, 0);
      send_word(CMD_QUERY, value_type'(32'h7FFF_FFFF), 2);
      send_word(CMD_SPARE, value_type'(32'h5A5A_A5A5), 0);
      send_word(CMD_REMOVE, value_type'(32'h0000_3039), 0);
      send_word(CMD_REMOVE, value_type'(32'h7FFF_FFFF), 3);
      send_word(CMD_REMOVE, value_type'(32'h8000_0000), 0);
      last_fill = '0;
      for (int i = 0; i < CAPACITY - 2; i++) begin
         last_fill = value_type'(32'h1357_0000 + i * 32'h0101_0101);
         send_word(CMD_ADD, last_fill, i % 2);
      end
      send_word(CMD_ADD, value_type'(32'hCAFE_0001), 0);
      send_word(CMD_ADD, '0, 0);
      send_word(CMD_QUERY, last_fill, 0);

      // Random: alternating fill and drain phases, with idle-free bursts.
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         send_word(pick_command(((n / 48) % 2) == 0), pick_value(),
                   ((n % 64) < 16) ? 0 : $urandom_range(0, 3));
      end
      @(negedge clock);
      req_bus.valid = 1'b0;

      // Drain: wait for every predicted answer, then a few quiet cycles.
      while (shadow.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (shadow.failures == 0 && shadow.outstanding() == 0) begin
         $display("bounded_integer_set regression: pass");
      end else begin
         $display("bounded_integer_set regression: fail");
      end
      $finish;
   end

endmodule
